/* sv/pbcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcd_pkg
// Types, op codes and constants for the pointer barrier crossing detector.
// ----------------------------------------------------------------------------
package pbcd_pkg;

   localparam int MaxBarriersDefault = 16;
   localparam int QuoWidth = 48;

   localparam logic [2:0] OP_MOTION   = 3'd0;
   localparam logic [2:0] OP_WRITE    = 3'd1;
   localparam logic [2:0] OP_CLEAR    = 3'd2;
   localparam logic [2:0] OP_ENABLE   = 3'd3;
   localparam logic [2:0] OP_DISABLE  = 3'd4;
   localparam logic [2:0] OP_DEACT    = 3'd5;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_ACT   = 2'd1;
   localparam logic [1:0] EV_DEACT = 2'd2;

   typedef struct packed {
      logic [2:0]         op;
      logic [3:0]         slot;
      logic signed [15:0] end_ax;
      logic signed [15:0] end_ay;
      logic signed [15:0] end_bx;
      logic signed [15:0] end_by;
      logic [31:0]        ident;
      logic signed [23:0] from_x;
      logic signed [23:0] from_y;
      logic signed [23:0] to_x;
      logic signed [23:0] to_y;
   } req_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [31:0]        activation_number;
      logic signed [23:0] hit_x;
      logic signed [23:0] hit_y;
      logic [31:0]        hit_barrier;
      logic               is_enabled;
      logic               is_active;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [QuoWidth-1:0] num;
      logic [QuoWidth-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [QuoWidth-1:0] quo;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_WAIT,
      ST_DONE
   } state_type;

endpackage

/* sv/pbcd_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcd_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbcd_divider
   import pbcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CntWidth = $clog2(QuoWidth + 1);

   logic [QuoWidth-1:0] quo_ff, quo_in;
   logic [QuoWidth:0]   rem_ff, rem_in;
   logic [QuoWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [QuoWidth:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[QuoWidth-1:0], quo_ff[QuoWidth-1]};
      if (div_req.start) begin
         quo_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = CntWidth'(QuoWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[QuoWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QuoWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

/* sv/pointer_barrier_crossing_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_barrier_crossing_detector
// Barrier table with a sequential scan; one shared serial divider
// interpolates the crossing point.
// ----------------------------------------------------------------------------
// Control ops go straight to the result state. A motion, when armed and not
// active, reads and checks each entry in turn, runs the multiply steps for each
// axis-aligned entry tested, and on a hit waits for the 48-bit serial divider.
// Throughput: one transaction at a time; busy is high until rsp_valid.
// Reset: flags, present bits and counter cleared; table contents undefined.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module pointer_barrier_crossing_detector
   import pbcd_pkg::*;
#(
   parameter int MAX_BARRIERS = MaxBarriersDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IdxWidth = (MAX_BARRIERS > 1) ? $clog2(MAX_BARRIERS) : 1;
   localparam int CntWidth = $clog2(MAX_BARRIERS + 1);

   logic [63:0] ends_mem [MAX_BARRIERS];
   logic [31:0] ident_mem [MAX_BARRIERS];
   logic [MAX_BARRIERS-1:0] present_ff, present_in;
   logic armed_ff, armed_in, capt_ff, capt_in;
   logic [31:0] count_ff, count_in;
   state_type state_ff, state_in;
   req_type req_ff;
   logic [CntWidth-1:0] idx_ff, idx_in;
   logic [63:0] ends_rd_ff;
   logic [31:0] ident_rd_ff;
   logic rd_present_ff;
   rsp_type rsp_ff, rsp_in;
   logic valid_ff, valid_in;
   logic [IdxWidth-1:0] idx_sel;
   logic [IdxWidth-1:0] wr_sel;
   logic wr_ok;

   // candidate registers
   logic signed [25:0] pa_ff, pb_ff, ca_ff, cb_ff, line_ff, lo_ff, hi_ff;
   logic signed [25:0] pa_in, pb_in, ca_in, cb_in, line_in, lo_in, hi_in;
   logic vert_ff, vert_in, neg_ff, neg_in;
   logic signed [26:0] d_ff, d_in;
   logic signed [55:0] n_ff, n_in;
   logic [1:0] mstep_ff, mstep_in;
   logic signed [55:0] m_ff, m_in;
   logic signed [26:0] mul_a;
   logic signed [26:0] mul_b;
   logic signed [55:0] mul_p;

   div_req_type div_req;
   div_rsp_type div_rsp;

   pbcd_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign idx_sel = idx_ff[IdxWidth-1:0];
   assign wr_sel  = IdxWidth'(req_data.slot);
   assign wr_ok   = (32'(req_data.slot) < 32'(MAX_BARRIERS));

   always_ff @(posedge clock) begin
      if (start && !busy && req_data.op == OP_WRITE && wr_ok) begin
         ends_mem[wr_sel]  <= {req_data.end_by, req_data.end_bx,
                               req_data.end_ay, req_data.end_ax};
         ident_mem[wr_sel] <= req_data.ident;
      end
      // entry held for the whole candidate evaluation
      if (state_ff == ST_READ) begin
         ends_rd_ff    <= ends_mem[idx_sel];
         ident_rd_ff   <= ident_mem[idx_sel];
         rd_present_ff <= present_ff[idx_sel];
      end
   end

   // shared multiplier: 27x27 signed, one product per cycle
   assign mul_p = 56'(mul_a * mul_b);

   logic signed [25:0] ex_ax, ex_ay, ex_bx, ex_by;
   logic signed [55:0] q_s;

   always_comb begin
      ex_ax = 26'(signed'(ends_rd_ff[15:0])) <<< 8;
      ex_ay = 26'(signed'(ends_rd_ff[31:16])) <<< 8;
      ex_bx = 26'(signed'(ends_rd_ff[47:32])) <<< 8;
      ex_by = 26'(signed'(ends_rd_ff[63:48])) <<< 8;
      q_s   = 56'(signed'({1'b0, div_rsp.quo}));
      if (neg_ff) q_s = -q_s;
   end

   always_comb begin
      state_in   = state_ff;
      present_in = present_ff;
      armed_in   = armed_ff;
      capt_in    = capt_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      rsp_in     = rsp_ff;
      valid_in   = 1'b0;
      pa_in = pa_ff; pb_in = pb_ff; ca_in = ca_ff; cb_in = cb_ff;
      line_in = line_ff; lo_in = lo_ff; hi_in = hi_ff;
      vert_in = vert_ff; neg_in = neg_ff; d_in = d_ff; n_in = n_ff;
      mstep_in = mstep_ff; m_in = m_ff;
      mul_a = '0;
      mul_b = '0;
      div_req.start = 1'b0;
      div_req.num   = QuoWidth'(n_ff);
      div_req.den   = QuoWidth'(d_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_in = '0;
               idx_in = '0;
               state_in = ST_DONE;
               unique case (req_data.op) inside
                  OP_MOTION: begin
                     if (armed_ff && !capt_ff) state_in = ST_READ;
                  end
                  OP_WRITE: begin
                     if (wr_ok) present_in[wr_sel] = 1'b1;
                  end
                  OP_CLEAR: present_in = '0;
                  OP_ENABLE: armed_in = 1'b1;
                  OP_DISABLE, OP_DEACT: begin
                     if (capt_ff) begin
                        capt_in = 1'b0;
                        rsp_in.event_kind = EV_DEACT;
                        rsp_in.activation_number = count_ff;
                     end
                     if (req_data.op == OP_DISABLE) armed_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (idx_ff == CntWidth'(MAX_BARRIERS)) state_in = ST_DONE;
            else state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_READ;
            idx_in = idx_ff + 1'b1;
            if (rd_present_ff && ident_rd_ff != 32'd0) begin
               if (ex_ax == ex_bx && ex_ay != ex_by) begin
                  vert_in = 1'b1;
                  pa_in = 26'(req_ff.from_x); pb_in = 26'(req_ff.from_y);
                  ca_in = 26'(req_ff.to_x);   cb_in = 26'(req_ff.to_y);
                  line_in = ex_ax;
                  lo_in = (ex_ay < ex_by) ? ex_ay : ex_by;
                  hi_in = (ex_ay < ex_by) ? ex_by : ex_ay;
                  state_in = ST_MUL;
               end else if (ex_ay == ex_by && ex_ax != ex_bx) begin
                  vert_in = 1'b0;
                  pa_in = 26'(req_ff.from_y); pb_in = 26'(req_ff.from_x);
                  ca_in = 26'(req_ff.to_y);   cb_in = 26'(req_ff.to_x);
                  line_in = ex_ay;
                  lo_in = (ex_ax < ex_bx) ? ex_ax : ex_bx;
                  hi_in = (ex_ax < ex_bx) ? ex_bx : ex_ax;
                  state_in = ST_MUL;
               end
               mstep_in = 2'd0;
            end
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 1'b1;
            unique case (mstep_ff)
               2'd0: begin
                  if (!((pa_ff < line_ff && ca_ff > line_ff) ||
                        (pa_ff > line_ff && ca_ff < line_ff))) begin
                     state_in = ST_READ;
                  end
                  d_in = 27'(ca_ff) - 27'(pa_ff);
                  neg_in = (ca_ff < pa_ff);
                  mul_a = 27'(pb_ff);
                  mul_b = 27'(ca_ff) - 27'(pa_ff);
                  m_in = mul_p;
               end
               2'd1: begin
                  mul_a = 27'(line_ff) - 27'(pa_ff);
                  mul_b = 27'(cb_ff) - 27'(pb_ff);
                  n_in = m_ff + mul_p;
                  if (neg_ff) d_in = -d_ff;
               end
               2'd2: begin
                  if (neg_ff) n_in = -n_ff;
                  mul_a = 27'(lo_ff);
                  mul_b = d_ff;
                  m_in = mul_p;
               end
               default: begin
                  mul_a = 27'(hi_ff);
                  mul_b = d_ff;
                  if (n_ff < m_ff || n_ff > mul_p) state_in = ST_READ;
                  else state_in = ST_DIV;
               end
            endcase
         end
         ST_DIV: begin
            neg_in = n_ff[55];
            div_req.start = 1'b1;
            div_req.num = QuoWidth'(n_ff[55] ? -n_ff : n_ff);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               capt_in  = 1'b1;
               count_in = count_ff + 32'd1;
               rsp_in.event_kind = EV_ACT;
               rsp_in.activation_number = count_ff + 32'd1;
               rsp_in.hit_barrier = ident_rd_ff;
               if (vert_ff) begin
                  rsp_in.hit_x = 24'(line_ff);
                  rsp_in.hit_y = 24'(q_s);
               end else begin
                  rsp_in.hit_x = 24'(q_s);
                  rsp_in.hit_y = 24'(line_ff);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            rsp_in.is_enabled = armed_ff;
            rsp_in.is_active  = capt_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         present_ff <= '0;
         armed_ff   <= 1'b0;
         capt_ff    <= 1'b0;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
         idx_ff     <= '0;
         mstep_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         present_ff <= present_in;
         armed_ff   <= armed_in;
         capt_ff    <= capt_in;
         count_ff   <= count_in;
         valid_ff   <= valid_in;
         idx_ff     <= idx_in;
         mstep_ff   <= mstep_in;
      end
      if (start && state_ff == ST_IDLE) req_ff <= req_data;
      rsp_ff <= rsp_in;
      pa_ff <= pa_in; pb_ff <= pb_in; ca_ff <= ca_in; cb_ff <= cb_in;
      line_ff <= line_in; lo_ff <= lo_in; hi_ff <= hi_in;
      vert_ff <= vert_in; neg_ff <= neg_in; d_ff <= d_in; n_ff <= n_in;
      m_ff <= m_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   a_valid_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid)
      else $error("result not presented");
   a_act_sets_capture: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == EV_ACT |-> rsp_data.is_active)
      else $error("activation without capture");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == ST_WAIT)
      else $error("counter moved outside activation");
   a_div_only_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_WAIT)
      else $error("divider done outside wait");

endmodule
